>>> sv/bpa_pkg.sv
// bpa_pkg: shared constants, codes and interface types of the bitmap page allocator
// no dependencies; imported by every module of the block but bpa_ram

package bpa_pkg;

  // map geometry
  localparam int MAX_PAGES  = 65536;
  localparam int PAGE_SHIFT = 12;
  localparam int MAP_WORDS  = (MAX_PAGES + 31) / 32;
  localparam int WIDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PG_W       = $clog2(MAX_PAGES + 1);

  // widths of the counter result fields and of the address arithmetic
  localparam int CNT_W  = 17;
  localparam int CALC_W = 34;

  localparam logic [CALC_W-1:0] PG_MASK_X   = CALC_W'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [CALC_W-1:0] ADDR_LIM_PG = CALC_W'(64'd1 << (32 - PAGE_SHIFT));
  localparam logic [CALC_W-1:0] MAX_PG_X    = CALC_W'(MAX_PAGES);

  // operation codes
  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_FREE       = 2'd1,
    OP_FREE_RANGE = 2'd2,
    OP_RESERVE    = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_NOFREE   = 3'd1,
    ST_MISALIGN = 3'd2,
    ST_RANGE    = 3'd3,
    ST_DOUBLE   = 3'd4,
    ST_EMPTY    = 3'd5
  } st_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_READ,
    S_MODIFY,
    S_REPLY
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic setup;
    logic clear_wr;
    logic word_mod;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic no_walk;
    logic walk_last;
  } dp_stat_t;

endpackage

>>> sv/bpa_ram.sv
// bpa_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bpa_ctrl.sv
// bpa_ctrl: sequencer of the page allocator (clearing pass, setup, word walk, reply)
// depends on bpa_pkg

module bpa_ctrl import bpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     busy,
  output logic     done
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_SETUP;
      end
      S_SETUP: begin
        state_next = stat.no_walk ? S_REPLY : S_READ;
      end
      S_READ: begin
        state_next = S_MODIFY;
      end
      S_MODIFY: begin
        state_next = stat.walk_last ? S_REPLY : S_READ;
      end
      S_REPLY: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_CLEAR:  cmd.clear_wr = 1'b1;
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_SETUP:  cmd.setup = 1'b1;
      S_READ:   cmd = '0;
      S_MODIFY: cmd.word_mod = 1'b1;
      S_REPLY:  done = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

>>> sv/bpa_dp.sv
// bpa_dp: allocator datapath: request registers, range setup, page map ram and counters
// depends on bpa_pkg and bpa_ram

module bpa_dp import bpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ctl_cmd_t         cmd,
  input  logic [1:0]       opcode,
  input  logic [31:0]      base_low,
  input  logic [31:0]      base_high,
  input  logic [31:0]      len_low,
  input  logic [31:0]      len_high,
  input  logic [31:0]      end_address,
  output dp_stat_t         stat,
  output logic [2:0]       status,
  output logic [31:0]      page_address,
  output logic [CNT_W-1:0] tracked_pages,
  output logic [CNT_W-1:0] free_count
);

  localparam logic [31:0] ONES = '1;

  // request registers
  op_t         op;
  logic [31:0] blo, bhi, llo, lhi, eaddr;

  // walk registers
  logic [WIDX_W-1:0] widx, lo_word, last_word;
  logic [4:0]        lo_bit, last_bit;

  // state and result registers
  logic [CNT_W-1:0] page_total, free_total;
  st_t              st;
  logic [31:0]      addr;

  // setup signals
  logic [CALC_W-1:0] blo_x, rf_start, rf_end_raw, rf_end, rv_start, rv_end_raw, rv_end;
  logic [CALC_W-1:0] pt_x, su_lo, su_hi;
  st_t               su_status;
  logic              su_walk, su_grow;
  logic [PG_W-1:0]   lo_pg, hm1_pg;

  // word step signals
  logic [31:0]      rdata, mask, fr, chg, new_word, hi_mask, wdata;
  logic [4:0]       lo_off, bidx;
  logic             hit, take;
  logic [5:0]       cnt;
  logic [CNT_W-1:0] free_next;
  logic             we;

  // capture request on accept
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= op_t'(opcode);
      blo   <= base_low;
      bhi   <= base_high;
      llo   <= len_low;
      lhi   <= len_high;
      eaddr <= end_address;
    end
  end

  // page bounds of each operation
  always_comb begin
    blo_x      = CALC_W'(blo);
    pt_x       = CALC_W'(page_total);
    rf_start   = (blo_x + PG_MASK_X) >> PAGE_SHIFT;
    rf_end_raw = (lhi != 32'd0) ? ADDR_LIM_PG : ((blo_x + CALC_W'(llo)) >> PAGE_SHIFT);
    rf_end     = rf_end_raw;
    if (rf_end > ADDR_LIM_PG) rf_end = ADDR_LIM_PG;
    if (rf_end > MAX_PG_X)    rf_end = MAX_PG_X;
    rv_start   = blo_x >> PAGE_SHIFT;
    rv_end_raw = (CALC_W'(eaddr) + PG_MASK_X) >> PAGE_SHIFT;
    rv_end     = (rv_end_raw > MAX_PG_X) ? MAX_PG_X : rv_end_raw;
  end

  // classify the request and pick the page range to walk
  always_comb begin
    su_status = ST_DONE;
    su_walk   = 1'b0;
    su_grow   = 1'b0;
    su_lo     = '0;
    su_hi     = CALC_W'(1);
    case (op)
      OP_ALLOC: begin
        su_status = ST_NOFREE;
        su_hi     = pt_x;
        su_walk   = (page_total != '0);
      end
      OP_FREE: begin
        if ((blo_x & PG_MASK_X) != '0) begin
          su_status = ST_MISALIGN;
        end else if (rv_start >= pt_x || rv_start >= MAX_PG_X) begin
          su_status = ST_RANGE;
        end else begin
          su_lo   = rv_start;
          su_hi   = rv_start + CALC_W'(1);
          su_walk = 1'b1;
        end
      end
      OP_FREE_RANGE: begin
        if (llo == 32'd0 && lhi == 32'd0) begin
          su_status = ST_EMPTY;
        end else if (bhi != 32'd0 || rf_start >= ADDR_LIM_PG) begin
          su_status = ST_RANGE;
        end else if (rf_start >= rf_end) begin
          su_status = ST_EMPTY;
        end else begin
          su_lo   = rf_start;
          su_hi   = rf_end;
          su_walk = 1'b1;
          su_grow = (rf_end > pt_x);
        end
      end
      OP_RESERVE: begin
        if (rv_start >= rv_end_raw) begin
          su_status = ST_EMPTY;
        end else if (rv_start < rv_end) begin
          su_lo   = rv_start;
          su_hi   = rv_end;
          su_walk = 1'b1;
        end
      end
      default: su_status = ST_DONE;
    endcase
    lo_pg  = PG_W'(su_lo);
    hm1_pg = PG_W'(su_hi - CALC_W'(1));
  end

  // bit mask of the pages of the current word inside the range
  always_comb begin
    lo_off  = (widx == lo_word) ? lo_bit : 5'd0;
    hi_mask = (widx == last_word) ? (ONES >> (5'd31 - last_bit)) : ONES;
    mask    = (ONES << lo_off) & hi_mask;
  end

  // read-modify-write of one map word
  always_comb begin
    fr   = ~rdata & mask;
    hit  = |fr;
    bidx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (fr[i]) bidx = 5'(i);
    end
    case (op)
      OP_ALLOC: begin
        chg      = fr & (~fr + 32'd1);
        new_word = rdata | chg;
        take     = 1'b1;
      end
      OP_RESERVE: begin
        chg      = fr;
        new_word = rdata | mask;
        take     = 1'b1;
      end
      default: begin
        chg      = rdata & mask;
        new_word = rdata & ~mask;
        take     = 1'b0;
      end
    endcase
    cnt = 6'($countones(chg));
    if (take) begin
      free_next = (free_total > CNT_W'(cnt)) ? (free_total - CNT_W'(cnt)) : '0;
    end else begin
      free_next = free_total + CNT_W'(cnt);
    end
  end

  // control and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      widx       <= '0;
      page_total <= '0;
      free_total <= '0;
      st         <= ST_DONE;
      addr       <= '0;
    end else begin
      if (cmd.clear_wr) begin
        widx <= widx + WIDX_W'(1);
      end
      if (cmd.setup) begin
        st   <= su_status;
        addr <= '0;
        widx <= WIDX_W'(lo_pg >> 5);
        if (su_grow) page_total <= CNT_W'(su_hi);
      end
      if (cmd.word_mod) begin
        free_total <= free_next;
        widx       <= widx + WIDX_W'(1);
        if (op == OP_ALLOC && hit) begin
          st   <= ST_DONE;
          addr <= 32'((CALC_W'({widx, bidx})) << PAGE_SHIFT);
        end
        if (op == OP_FREE && chg == '0) begin
          st <= ST_DOUBLE;
        end
      end
    end
  end

  // range bounds for the walk
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      lo_word   <= WIDX_W'(lo_pg >> 5);
      lo_bit    <= lo_pg[4:0];
      last_word <= WIDX_W'(hm1_pg >> 5);
      last_bit  <= hm1_pg[4:0];
    end
  end

  // page map storage, read every cycle at the walk index
  assign we    = cmd.clear_wr | cmd.word_mod;
  assign wdata = cmd.clear_wr ? ONES : new_word;

  bpa_ram #(
    .WIDTH(32),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(widx),
    .wdata(wdata),
    .raddr(widx),
    .rdata(rdata)
  );

  // status to the controller
  assign stat.clear_last = (widx == WIDX_W'(MAP_WORDS - 1));
  assign stat.no_walk    = ~su_walk;
  assign stat.walk_last  = (widx == last_word) || (op == OP_ALLOC && hit);

  // result fields
  assign status        = st;
  assign page_address  = addr;
  assign tracked_pages = page_total;
  assign free_count    = free_total;

endmodule

>>> sv/bitmap_page_allocator_top.sv
// bitmap_page_allocator_top: top level of the bitmap first-fit page allocator
// depends on bpa_pkg, bpa_ctrl, bpa_dp (and bpa_ram through bpa_dp)

// The allocator keeps one bit per page in a 2048 x 32 map ram. After reset it
// runs a clearing pass (one map word per cycle) that marks every page used;
// busy stays high meanwhile. A request is taken when start is high and busy
// low, and its result appears on the result ports for one cycle with done
// high; the receiver must sample it then. A request rejected from its fields
// alone (misaligned, out of range, empty) goes from setup straight to the
// result without reading the map. A request whose range lies in the map walks
// the map words it touches, reading each word from the ram, then modifying it
// and writing it back, from the first to the last page of the range; a single
// free touches one word, and an alloc stops at the word that holds the first
// free page, at most ceil(tracked_pages / 32) words. busy stays high until the
// result cycle ends.

module bitmap_page_allocator_top import bpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       opcode,
  input  logic [31:0]      base_low,
  input  logic [31:0]      base_high,
  input  logic [31:0]      len_low,
  input  logic [31:0]      len_high,
  input  logic [31:0]      end_address,
  output logic             done,
  output logic [2:0]       status,
  output logic [31:0]      page_address,
  output logic [CNT_W-1:0] tracked_pages,
  output logic [CNT_W-1:0] free_count
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer
  bpa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  // datapath with the page map
  bpa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .opcode       (opcode),
    .base_low     (base_low),
    .base_high    (base_high),
    .len_low      (len_low),
    .len_high     (len_high),
    .end_address  (end_address),
    .stat         (stat),
    .status       (status),
    .page_address (page_address),
    .tracked_pages(tracked_pages),
    .free_count   (free_count)
  );

endmodule

>>> sv/bpa_checker.sv
// bpa_checker: port-level assertions for the page allocator, bound to the top level
// depends on bpa_pkg

module bpa_checker import bpa_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [2:0]       status,
  input logic [31:0]      page_address,
  input logic [CNT_W-1:0] tracked_pages,
  input logic [CNT_W-1:0] free_count
);

  // a result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // no new request can be taken while a result is shown
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result shown while block idle");

  // only a successful alloc carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DONE) |-> (page_address == 32'd0))
    else $error("address given with a failure status");

  // counters never exceed the map capacity
  a_counts: assert property (@(posedge clk) disable iff (rst)
    done |-> (tracked_pages <= CNT_W'(MAX_PAGES) && free_count <= CNT_W'(MAX_PAGES)))
    else $error("counter beyond map capacity");

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .page_address (page_address),
  .tracked_pages(tracked_pages),
  .free_count   (free_count)
);

>>> sim/testbench.sv
// testbench: self-checking bench for the bitmap page allocator top level
// drives directed then random page transactions and compares each result
// against a local predictor; depends on bpa_pkg and bitmap_page_allocator_top

module testbench import bpa_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // run shape
  localparam int          RANDOM_ITEMS = 1525;
  localparam int          IDLE_LIMIT   = 80000;
  localparam int          DRAIN_CYCLES = 16;
  localparam int unsigned LOW_PAGES    = 256;
  localparam int unsigned LOW_BYTES    = LOW_PAGES << PAGE_SHIFT;
  localparam int unsigned SMALL_SPAN   = 16 << PAGE_SHIFT;

  // address arithmetic in 64 bits
  localparam longint unsigned PAGE_OFS  = (64'd1 << PAGE_SHIFT) - 64'd1;
  localparam longint unsigned FOUR_GIB  = 64'h1_0000_0000;
  localparam longint unsigned MAP_BYTES = 64'(MAX_PAGES) << PAGE_SHIFT;

  typedef struct packed {
    op_t         op;
    logic [31:0] base_low;
    logic [31:0] base_high;
    logic [31:0] len_low;
    logic [31:0] len_high;
    logic [31:0] end_address;
  } page_req_t;

  typedef struct packed {
    st_t              status;
    logic [31:0]      page_address;
    logic [CNT_W-1:0] tracked_pages;
    logic [CNT_W-1:0] free_count;
  } page_res_t;

  typedef struct {
    page_req_t req;
    bit        known;
    page_res_t res;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       opcode = '0;
  logic [31:0]      base_low = '0;
  logic [31:0]      base_high = '0;
  logic [31:0]      len_low = '0;
  logic [31:0]      len_high = '0;
  logic [31:0]      end_address = '0;
  logic             busy;
  logic             done;
  logic [2:0]       status;
  logic [31:0]      page_address;
  logic [CNT_W-1:0] tracked_pages;
  logic [CNT_W-1:0] free_count;

  // predictor state: one bit per page, set when used
  bit              page_busy_map [0:MAX_PAGES-1];
  longint unsigned pages_tracked;
  longint unsigned pages_free;

  page_res_t pending_results [$];
  dir_row_t  directed_rows [$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;

  bitmap_page_allocator_top u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .base_low(base_low),
    .base_high(base_high),
    .len_low(len_low),
    .len_high(len_high),
    .end_address(end_address),
    .done(done),
    .status(status),
    .page_address(page_address),
    .tracked_pages(tracked_pages),
    .free_count(free_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mark a page used; free count floors at zero
  function automatic void claim_page(input longint unsigned pg);
    if (!page_busy_map[pg]) begin
      page_busy_map[pg] = 1'b1;
      if (pages_free > 0) pages_free--;
    end
  endfunction

  // mark a page free; only a used page counts
  function automatic void release_page(input longint unsigned pg);
    if (page_busy_map[pg]) begin
      page_busy_map[pg] = 1'b0;
      pages_free++;
    end
  endfunction

  // apply one transaction to the predictor state and return its result
  function automatic page_res_t predict_page_op(input page_req_t r);
    page_res_t       e;
    longint unsigned base, len, first, last, p, pe;
    bit              found;
    e.status       = ST_DONE;
    e.page_address = '0;
    found          = 1'b0;
    case (r.op)
      OP_ALLOC: begin
        e.status = ST_NOFREE;
        for (p = 0; p < pages_tracked && p < MAX_PAGES && !found; p++) begin
          if (!page_busy_map[p]) begin
            claim_page(p);
            e.page_address = 32'(p << PAGE_SHIFT);
            e.status       = ST_DONE;
            found          = 1'b1;
          end
        end
      end
      OP_FREE: begin
        base = 64'(r.base_low);
        p    = base >> PAGE_SHIFT;
        if ((base & PAGE_OFS) != 0) e.status = ST_MISALIGN;
        else if (p >= pages_tracked || p >= MAX_PAGES) e.status = ST_RANGE;
        else if (!page_busy_map[p]) e.status = ST_DOUBLE;
        else release_page(p);
      end
      OP_FREE_RANGE: begin
        base = {r.base_high, r.base_low};
        len  = {r.len_high, r.len_low};
        if (len == 0) begin
          e.status = ST_EMPTY;
        end else if (r.base_high != 0) begin
          e.status = ST_RANGE;
        end else begin
          // round the start up and the end down
          first = (base + PAGE_OFS) & ~PAGE_OFS;
          if (first >= FOUR_GIB) begin
            e.status = ST_RANGE;
          end else begin
            if (len >= FOUR_GIB) last = FOUR_GIB;
            else last = (base + len) & ~PAGE_OFS;
            if (last > FOUR_GIB) last = FOUR_GIB;
            if (last > MAP_BYTES) last = MAP_BYTES;
            if (first >= last) begin
              e.status = ST_EMPTY;
            end else begin
              pe = last >> PAGE_SHIFT;
              if (pe > pages_tracked) pages_tracked = pe;
              for (p = first >> PAGE_SHIFT; p < pe; p++) release_page(p);
            end
          end
        end
      end
      default: begin
        // reserve rounds outward, end rounded without a 32-bit wrap
        p  = 64'(r.base_low) >> PAGE_SHIFT;
        pe = (64'(r.end_address) + PAGE_OFS) >> PAGE_SHIFT;
        if (p >= pe) begin
          e.status = ST_EMPTY;
        end else begin
          if (pe > MAX_PAGES) pe = MAX_PAGES;
          for (; p < pe; p++) claim_page(p);
        end
      end
    endcase
    e.tracked_pages = pages_tracked[CNT_W-1:0];
    e.free_count    = pages_free[CNT_W-1:0];
    return e;
  endfunction

  function automatic void dir_row(input op_t op, input logic [31:0] bl, input logic [31:0] bh,
                                  input logic [31:0] ll, input logic [31:0] lh,
                                  input logic [31:0] ea, input bit known, input st_t st,
                                  input logic [31:0] addr, input logic [CNT_W-1:0] trk,
                                  input logic [CNT_W-1:0] frc);
    dir_row_t row;
    row.req   = '{op, bl, bh, ll, lh, ea};
    row.known = known;
    row.res   = '{st, addr, trk, frc};
    directed_rows.push_back(row);
  endfunction

  // random transaction, mostly kept to the low pages so walks stay short
  function automatic page_req_t random_page_req();
    page_req_t   r;
    int unsigned pick, sel;
    r.op          = op_t'($urandom_range(3, 0));
    r.base_low    = $urandom;
    r.base_high   = $urandom;
    r.len_low     = $urandom;
    r.len_high    = $urandom;
    r.end_address = $urandom;
    pick          = $urandom_range(99, 0);
    sel           = $urandom_range(9, 0);
    if (pages_free < 32 && pick < 70) begin
      // refill the low pages so allocs keep finding space
      r.op        = OP_FREE_RANGE;
      r.base_high = '0;
      r.len_high  = '0;
      r.base_low  = $urandom_range(LOW_BYTES - 1, 0);
      r.len_low   = $urandom_range(LOW_BYTES, 1);
    end else if (pick == 0) begin
      // free up to the map end through a live upper length word
      r.op        = OP_FREE_RANGE;
      r.base_high = '0;
      r.base_low  = $urandom_range(LOW_BYTES - 1, 0);
    end else if (pick == 1) begin
      // reserve from the low pages to a far end
      r.op       = OP_RESERVE;
      r.base_low = $urandom_range(LOW_BYTES - 1, 0);
    end else if (pick >= 5) begin
      case (r.op)
        OP_FREE: begin
          if (sel < 8) r.base_low = $urandom_range(LOW_PAGES + 31, 0) << PAGE_SHIFT;
          else if (sel == 8) r.base_low = $urandom_range(LOW_BYTES, 0);
        end
        OP_FREE_RANGE: begin
          if (sel != 0) begin
            r.base_high = '0;
            r.len_high  = '0;
            r.base_low  = $urandom_range(LOW_BYTES - 1, 0);
            r.len_low   = $urandom_range(SMALL_SPAN, 0);
          end
        end
        OP_RESERVE: begin
          r.base_low = $urandom_range(LOW_BYTES - 1, 0);
          if (sel != 0) r.end_address = r.base_low + $urandom_range(SMALL_SPAN, 0);
          else r.end_address = $urandom_range(r.base_low, 0);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // bursts of back-to-back transactions separated by random gaps
  function automatic int next_gap();
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(80, 20) : $urandom_range(12, 1);
      gap        = $urandom_range(40, 1);
    end
    burst_left--;
    return gap;
  endfunction

  // present one transaction and wait until it is taken
  task automatic issue_txn(input page_req_t r, input page_res_t want, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start       <= 1'b1;
    opcode      <= r.op;
    base_low    <= r.base_low;
    base_high   <= r.base_high;
    len_low     <= r.len_low;
    len_high    <= r.len_high;
    end_address <= r.end_address;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_results.push_back(want);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    page_res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no pending transaction", 32'(status), '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          flag_mismatch("status", 32'(status), 32'(want.status));
        if (page_address !== want.page_address)
          flag_mismatch("page_address", page_address, want.page_address);
        if (tracked_pages !== want.tracked_pages)
          flag_mismatch("tracked_pages", 32'(tracked_pages), 32'(want.tracked_pages));
        if (free_count !== want.free_count)
          flag_mismatch("free_count", 32'(free_count), 32'(want.free_count));
      end
    end
  end

  // watchdog on cycles with no transaction taken and no result
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || done === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[bitmap_page_allocator_top] ERROR");
      $finish;
    end
  end

  initial begin
    page_req_t req;
    page_res_t want;
    foreach (page_busy_map[i]) page_busy_map[i] = 1'b1;
    pages_tracked = 0;
    pages_free    = 0;

    // directed table: op, base lo/hi, length lo/hi, end, known?, status, addr, tracked, free
    dir_row(OP_ALLOC, 0, 0, 0, 0, 0, 1, ST_NOFREE, 0, 0, 0);
    dir_row(OP_FREE, 32'h0, 0, 0, 0, 0, 1, ST_RANGE, 0, 0, 0);
    dir_row(OP_FREE, 32'h1, 0, 0, 0, 0, 1, ST_MISALIGN, 0, 0, 0);
    dir_row(OP_FREE_RANGE, 32'h0, 0, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0);
    dir_row(OP_FREE_RANGE, 32'h0, 32'h1, 32'h1000, 0, 0, 1, ST_RANGE, 0, 0, 0);
    dir_row(OP_FREE_RANGE, 32'hFFFF_F001, 0, 32'h1000, 0, 0, 1, ST_RANGE, 0, 0, 0);
    dir_row(OP_FREE_RANGE, 32'h0, 0, 32'hFFF, 0, 0, 1, ST_EMPTY, 0, 0, 0);
    dir_row(OP_FREE_RANGE, 32'h0, 0, 32'h8000, 0, 0, 1, ST_DONE, 0, 8, 8);
    // page zero is a good alloc with address zero
    dir_row(OP_ALLOC, 0, 0, 0, 0, 0, 1, ST_DONE, 32'h0, 8, 7);
    dir_row(OP_ALLOC, 0, 0, 0, 0, 0, 1, ST_DONE, 32'h1000, 8, 6);
    dir_row(OP_FREE, 32'h0, 0, 0, 0, 0, 1, ST_DONE, 0, 8, 7);
    dir_row(OP_FREE, 32'h0, 0, 0, 0, 0, 1, ST_DOUBLE, 0, 8, 7);
    dir_row(OP_FREE, 32'h8000, 0, 0, 0, 0, 1, ST_RANGE, 0, 8, 7);
    dir_row(OP_RESERVE, 32'h0, 0, 0, 0, 32'h0, 1, ST_EMPTY, 0, 8, 7);
    dir_row(OP_RESERVE, 32'h1000, 0, 0, 0, 32'h1000, 1, ST_EMPTY, 0, 8, 7);
    dir_row(OP_RESERVE, 32'h0, 0, 0, 0, 32'h8000, 1, ST_DONE, 0, 8, 0);
    dir_row(OP_ALLOC, 0, 0, 0, 0, 0, 1, ST_NOFREE, 0, 8, 0);
    // inward rounding of an unaligned range
    dir_row(OP_FREE_RANGE, 32'h800, 0, 32'h1800, 0, 0, 0, ST_DONE, 0, 0, 0);
    // length of 4 GiB or more clamps to the whole map
    dir_row(OP_FREE_RANGE, 32'h0, 0, 32'h0, 32'h1, 0, 1, ST_DONE, 0, 17'd65536, 17'd65536);
    dir_row(OP_ALLOC, 0, 0, 0, 0, 0, 1, ST_DONE, 32'h0, 17'd65536, 17'd65535);
    dir_row(OP_FREE_RANGE, 32'hFFFF_F000, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, ST_EMPTY,
            0, 17'd65536, 17'd65535);
    // reserve end rounds past 4 GiB without wrapping, pages beyond the map skipped
    dir_row(OP_RESERVE, 32'hFFFF_F000, 0, 0, 0, 32'hFFFF_FFFF, 1, ST_DONE,
            0, 17'd65536, 17'd65535);
    dir_row(OP_RESERVE, 32'h0, 0, 0, 0, 32'hFFFF_FFFF, 1, ST_DONE, 0, 17'd65536, 0);
    dir_row(OP_ALLOC, 0, 0, 0, 0, 0, 1, ST_NOFREE, 0, 17'd65536, 0);
    dir_row(OP_FREE, 32'hFFFF_F000, 0, 0, 0, 0, 1, ST_RANGE, 0, 17'd65536, 0);
    dir_row(OP_FREE, 32'h0FFF_F000, 0, 0, 0, 0, 1, ST_DONE, 0, 17'd65536, 1);
    dir_row(OP_ALLOC, 0, 0, 0, 0, 0, 1, ST_DONE, 32'h0FFF_F000, 17'd65536, 0);

    // reset once
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed part
    foreach (directed_rows[i]) begin
      want = predict_page_op(directed_rows[i].req);
      if (directed_rows[i].known) want = directed_rows[i].res;
      issue_txn(directed_rows[i].req, want, next_gap());
    end

    // random part
    repeat (RANDOM_ITEMS) begin
      req  = random_page_req();
      want = predict_page_op(req);
      issue_txn(req, want, next_gap());
    end
    @(negedge clk);
    start <= 1'b0;

    // drain and finish
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("[bitmap_page_allocator_top] OK");
    else $display("[bitmap_page_allocator_top] ERROR");
    $finish;
  end

endmodule
